[hdl/queue_redirect_decider_top_defines.svh]
// ---------------------------------------------------------------------------
// Queue redirect decider assertion macros
// Shared immediate-consequence and next-cycle property forms.
// ---------------------------------------------------------------------------
`ifndef QUEUE_REDIRECT_DECIDER_TOP_DEFINES_SVH
`define QUEUE_REDIRECT_DECIDER_TOP_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define QRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define QRD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/qrd_pkg.sv]
// ---------------------------------------------------------------------------
// Queue redirect decider package
// Register map, configuration record and divider control types.
// ---------------------------------------------------------------------------
package qrd_pkg;

    localparam int REG_W      = 16;
    localparam int CNT_W      = 17;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_QUEUE_LIMIT      = 3'd0,
        REG_HOLD_STEPS       = 3'd1,
        REG_RAID_ACCESS_TIME = 3'd2,
        REG_RAID_WAIT        = 3'd3,
        REG_IC_WAIT          = 3'd4,
        REG_IC_CHECKUP_TIME  = 3'd5,
        REG_IC_THROUGHPUT    = 3'd6,
        REG_RAID_THROUGHPUT  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [REG_W-1:0] queue_limit;
        logic [REG_W-1:0] hold_steps;
        logic [REG_W-1:0] raid_access_time;
        logic [REG_W-1:0] raid_wait_per_entry;
        logic [REG_W-1:0] ic_wait_per_entry;
        logic [REG_W-1:0] ic_checkup_time;
        logic [REG_W-1:0] ic_throughput;
        logic [REG_W-1:0] raid_throughput;
    } t_cfg;

    // Divider launch: wide runs over the full threshold numerator,
    // otherwise over a depth-wide numerator only.
    typedef struct packed {
        logic start;
        logic wide;
    } t_div_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

[hdl/qrd_ifs.sv]
// ---------------------------------------------------------------------------
// Queue redirect decider stream interfaces
// Sample request channel and decision result channel.
// ---------------------------------------------------------------------------
interface qrd_in_if #(parameter int DEPTH_WIDTH = 16);
    logic                   valid;
    logic                   ready;
    logic [DEPTH_WIDTH-1:0] ic_depth;
    logic [DEPTH_WIDTH-1:0] raid_depth;

    modport source (output valid, output ic_depth, output raid_depth, input ready);
    modport sink   (input valid, input ic_depth, input raid_depth, output ready);
endinterface

interface qrd_out_if;
    logic                      valid;
    logic                      ready;
    logic                      use_interconnect;
    logic [qrd_pkg::CNT_W-1:0] hold_left;

    modport source (output valid, output use_interconnect, output hold_left, input ready);
    modport sink   (input valid, input use_interconnect, input hold_left, output ready);
endinterface

[hdl/qrd_cfg.sv]
// ---------------------------------------------------------------------------
// Queue redirect decider register file
// APB-style write/read access to the eight 16-bit control registers.
// ---------------------------------------------------------------------------
module qrd_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qrd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [qrd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [qrd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output qrd_pkg::t_cfg                  o_cfg
);

    qrd_pkg::t_cfg                r_cfg;
    qrd_pkg::t_reg_idx            idx;
    logic [qrd_pkg::REG_W-1:0]    wval;
    logic [qrd_pkg::REG_W-1:0]    rval;
    logic                         wr_en;

    assign idx    = qrd_pkg::t_reg_idx'(paddr[qrd_pkg::APB_ADDR_W-1:2]);
    assign wval   = pwdata[qrd_pkg::REG_W-1:0];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg                     <= '0;
            r_cfg.ic_wait_per_entry   <= qrd_pkg::REG_W'(1);
            r_cfg.ic_throughput       <= qrd_pkg::REG_W'(1);
            r_cfg.raid_throughput     <= qrd_pkg::REG_W'(1);
        end else if (wr_en) begin
            case (idx)
                qrd_pkg::REG_QUEUE_LIMIT:      r_cfg.queue_limit         <= wval;
                qrd_pkg::REG_HOLD_STEPS:       r_cfg.hold_steps          <= wval;
                qrd_pkg::REG_RAID_ACCESS_TIME: r_cfg.raid_access_time    <= wval;
                qrd_pkg::REG_RAID_WAIT:        r_cfg.raid_wait_per_entry <= wval;
                qrd_pkg::REG_IC_WAIT:          r_cfg.ic_wait_per_entry   <= wval;
                qrd_pkg::REG_IC_CHECKUP_TIME:  r_cfg.ic_checkup_time     <= wval;
                qrd_pkg::REG_IC_THROUGHPUT:    r_cfg.ic_throughput       <= wval;
                qrd_pkg::REG_RAID_THROUGHPUT:  r_cfg.raid_throughput     <= wval;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            qrd_pkg::REG_QUEUE_LIMIT:      rval = r_cfg.queue_limit;
            qrd_pkg::REG_HOLD_STEPS:       rval = r_cfg.hold_steps;
            qrd_pkg::REG_RAID_ACCESS_TIME: rval = r_cfg.raid_access_time;
            qrd_pkg::REG_RAID_WAIT:        rval = r_cfg.raid_wait_per_entry;
            qrd_pkg::REG_IC_WAIT:          rval = r_cfg.ic_wait_per_entry;
            qrd_pkg::REG_IC_CHECKUP_TIME:  rval = r_cfg.ic_checkup_time;
            qrd_pkg::REG_IC_THROUGHPUT:    rval = r_cfg.ic_throughput;
            qrd_pkg::REG_RAID_THROUGHPUT:  rval = r_cfg.raid_throughput;
            default:                       rval = '0;
        endcase
    end

    assign prdata = qrd_pkg::APB_DATA_W'(rval);

endmodule

[hdl/qrd_div.sv]
// ---------------------------------------------------------------------------
// Queue redirect decider shared divider
// Restoring division, one quotient bit per cycle, 16-bit divisor.
// ---------------------------------------------------------------------------
`include "queue_redirect_decider_top_defines.svh"

module qrd_div #(
    parameter int DEPTH_WIDTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  qrd_pkg::t_div_cmd                    i_cmd,
    input  logic [DEPTH_WIDTH+qrd_pkg::REG_W:0]  i_num,
    input  logic [qrd_pkg::REG_W-1:0]            i_den,
    output qrd_pkg::t_div_sts                    o_sts,
    output logic [DEPTH_WIDTH+qrd_pkg::REG_W:0]  o_quo,
    output logic [qrd_pkg::REG_W-1:0]            o_rem
);

    localparam int NW = DEPTH_WIDTH + qrd_pkg::REG_W + 1;
    localparam int CW = $clog2(NW + 1);
    localparam int PW = NW - DEPTH_WIDTH;

    logic                      r_busy;
    logic                      r_done;
    logic [CW-1:0]             r_cnt;
    logic [NW-1:0]             r_num;
    logic [NW-1:0]             r_quo;
    logic [qrd_pkg::REG_W-1:0] r_rem;
    logic [qrd_pkg::REG_W-1:0] r_den;

    logic [qrd_pkg::REG_W:0]   rem_sh;
    logic [qrd_pkg::REG_W:0]   rem_sub;
    logic                      ge;

    assign rem_sh  = {r_rem, r_num[NW-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_cmd.wide ? CW'(NW) : CW'(DEPTH_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // A narrow run left-aligns the depth so its quotient lands in the low bits.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_num <= i_cmd.wide ? i_num : {i_num[DEPTH_WIDTH-1:0], {PW{1'b0}}};
            r_quo <= '0;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_quo <= {r_quo[NW-2:0], ge};
            r_rem <= ge ? rem_sub[qrd_pkg::REG_W-1:0] : rem_sh[qrd_pkg::REG_W-1:0];
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quo      = r_quo;
    assign o_rem      = r_rem;

    `QRD_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_cmd.start, r_busy, "divider did not start")
    `QRD_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, r_done, !r_busy, "divider done while busy")
    `QRD_ASSERT_NOW(a_busy_cnt, i_clk, i_rst_n, r_busy, r_cnt != '0, "divider busy with no steps")

endmodule

[hdl/qrd_ctrl.sv]
// ---------------------------------------------------------------------------
// Queue redirect decider sequencer
// Holds the hold counter and steps the adaptive computation on the divider.
// ---------------------------------------------------------------------------
`include "queue_redirect_decider_top_defines.svh"

module qrd_ctrl #(
    parameter int DEPTH_WIDTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  qrd_pkg::t_cfg                        i_cfg,
    input  logic                                 i_req_valid,
    input  logic [DEPTH_WIDTH-1:0]               i_ic_depth,
    input  logic [DEPTH_WIDTH-1:0]               i_raid_depth,
    output logic                                 o_req_ready,
    output logic                                 o_rsp_valid,
    input  logic                                 i_rsp_ready,
    output logic                                 o_use_interconnect,
    output logic [qrd_pkg::CNT_W-1:0]            o_hold_left,
    output qrd_pkg::t_div_cmd                    o_div_cmd,
    output logic [DEPTH_WIDTH+qrd_pkg::REG_W:0]  o_div_num,
    output logic [qrd_pkg::REG_W-1:0]            o_div_den,
    input  qrd_pkg::t_div_sts                    i_div_sts,
    input  logic [DEPTH_WIDTH+qrd_pkg::REG_W:0]  i_div_quo,
    input  logic [qrd_pkg::REG_W-1:0]            i_div_rem
);

    localparam int NW = DEPTH_WIDTH + qrd_pkg::REG_W + 1;
    localparam int PW = DEPTH_WIDTH + qrd_pkg::REG_W;
    localparam int XW = (DEPTH_WIDTH > qrd_pkg::REG_W) ? DEPTH_WIDTH : qrd_pkg::REG_W;
    localparam int SW = DEPTH_WIDTH + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_T_GO, S_T_WAIT, S_IC_GO, S_IC_WAIT, S_RD_GO, S_OUT
    } t_state;

    t_state                    r_state, n_state;
    logic [DEPTH_WIDTH-1:0]    r_ic, n_ic;
    logic [DEPTH_WIDTH-1:0]    r_raid, n_raid;
    logic [NW-1:0]             r_total, n_total;
    logic [NW-1:0]             r_thr, n_thr;
    logic [SW-1:0]             r_steps_ic, n_steps_ic;
    logic [qrd_pkg::CNT_W-1:0] r_cnt, n_cnt;

    logic                      accept;
    logic [PW-1:0]             prod;
    logic [NW-1:0]             diff;
    logic [qrd_pkg::CNT_W-1:0] cnt_ld;
    logic [SW-1:0]             steps_div;
    logic                      den_zero;
    logic                      rd_wait;

    assign accept = i_req_valid && (r_state == S_IDLE);
    assign prod   = PW'(r_raid) * PW'(i_cfg.raid_wait_per_entry);
    assign diff   = (r_total > NW'(i_cfg.ic_checkup_time))
                  ? r_total - NW'(i_cfg.ic_checkup_time) : '0;

    // Fixed mode: an overfull sample reloads the counter before the countdown.
    assign cnt_ld = (XW'(i_ic_depth) > XW'(i_cfg.queue_limit))
                  ? {1'b0, i_cfg.hold_steps} + qrd_pkg::CNT_W'(1) : r_cnt;

    // Ceiling division; a zero throughput means the largest step count.
    assign den_zero  = (o_div_den == '0);
    assign steps_div = den_zero ? '1
                     : SW'(i_div_quo[DEPTH_WIDTH-1:0]) + SW'(i_div_rem != '0);

    // The array step count is finished in the state after its launch.
    assign rd_wait = (r_state == S_OUT) && !o_rsp_valid;

    always_comb begin
        o_div_cmd.start = 1'b0;
        o_div_cmd.wide  = 1'b0;
        o_div_num       = NW'(r_ic);
        o_div_den       = i_cfg.ic_throughput;
        case (r_state)
            S_T_GO: begin
                o_div_cmd.start = 1'b1;
                o_div_cmd.wide  = 1'b1;
                o_div_num       = diff;
                o_div_den       = i_cfg.ic_wait_per_entry;
            end
            S_T_WAIT: begin
                o_div_num = diff;
                o_div_den = i_cfg.ic_wait_per_entry;
            end
            S_IC_GO: begin
                o_div_cmd.start = 1'b1;
            end
            S_RD_GO: begin
                o_div_cmd.start = 1'b1;
                o_div_num       = NW'(r_raid);
                o_div_den       = i_cfg.raid_throughput;
            end
            S_OUT: begin
                o_div_num = NW'(r_raid);
                o_div_den = i_cfg.raid_throughput;
            end
            default: ;
        endcase
    end

    logic r_rsp_valid, n_rsp_valid;

    always_comb begin
        n_state     = r_state;
        n_ic        = r_ic;
        n_raid      = r_raid;
        n_total     = r_total;
        n_thr       = r_thr;
        n_steps_ic  = r_steps_ic;
        n_cnt       = r_cnt;
        n_rsp_valid = r_rsp_valid;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_ic   = i_ic_depth;
                    n_raid = i_raid_depth;
                    if (i_cfg.queue_limit != '0) begin
                        n_cnt       = (cnt_ld != '0) ? cnt_ld - qrd_pkg::CNT_W'(1) : '0;
                        n_rsp_valid = 1'b1;
                        n_state     = S_OUT;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_total = NW'(prod) + NW'(i_cfg.raid_access_time);
                n_state = S_T_GO;
            end
            S_T_GO:  n_state = S_T_WAIT;
            S_T_WAIT: begin
                if (i_div_sts.done) begin
                    n_thr   = i_div_quo;
                    n_state = S_IC_GO;
                end
            end
            S_IC_GO: n_state = S_IC_WAIT;
            S_IC_WAIT: begin
                if (i_div_sts.done) begin
                    n_steps_ic = steps_div;
                    n_state    = S_RD_GO;
                end
            end
            S_RD_GO: n_state = S_OUT;
            S_OUT: begin
                if (!r_rsp_valid) begin
                    if (i_div_sts.done) begin
                        n_cnt = ((NW'(r_ic) > r_thr) || (r_steps_ic > steps_div))
                              ? qrd_pkg::CNT_W'(1) : '0;
                        n_rsp_valid = 1'b1;
                    end
                end else if (i_rsp_ready) begin
                    n_rsp_valid = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rsp_valid <= n_rsp_valid;
            r_ic        <= n_ic;
            r_raid      <= n_raid;
            r_total     <= n_total;
            r_thr       <= n_thr;
            r_steps_ic  <= n_steps_ic;
        end
    end

    assign o_req_ready        = (r_state == S_IDLE);
    assign o_rsp_valid        = r_rsp_valid;
    assign o_use_interconnect = (r_cnt == '0);
    assign o_hold_left        = r_cnt;

    `QRD_ASSERT_NOW(a_start_free, i_clk, i_rst_n, o_div_cmd.start, !i_div_sts.busy, "divider launched while busy")
    `QRD_ASSERT_NOW(a_done_wait, i_clk, i_rst_n, i_div_sts.done, (r_state == S_T_WAIT) || (r_state == S_IC_WAIT) || rd_wait, "unexpected divider result")
    `QRD_ASSERT_NXT(a_fixed_fast, i_clk, i_rst_n, accept && (i_cfg.queue_limit != '0), o_rsp_valid, "fixed mode result late")
    `QRD_ASSERT_NOW(a_adapt_bin, i_clk, i_rst_n, o_rsp_valid && (i_cfg.queue_limit == '0), o_hold_left[qrd_pkg::CNT_W-1:1] == '0, "adaptive counter above one")

endmodule

[hdl/queue_redirect_decider_top.sv]
// Fixed mode (queue_limit nonzero) gives the result in the cycle after the request.
// Adaptive mode runs a multiply step, then three divisions in turn on the shared
// one-bit-per-cycle divider.
// Throughput: one request at a time; the next is taken the cycle after the result leaves.
// Reset: i_rst_n synchronous, active low; clears the hold counter and control state
// and loads the register reset values (divisor registers to 1, all others to 0).
// ---------------------------------------------------------------------------
// Queue redirect decider top level
// Routes requests via the interconnect or straight to the storage array.
// ---------------------------------------------------------------------------
module queue_redirect_decider_top #(
    parameter int DEPTH_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    qrd_in_if.sink                         i_req,
    qrd_out_if.source                      o_rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qrd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [qrd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [qrd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam int NW = DEPTH_WIDTH + qrd_pkg::REG_W + 1;

    qrd_pkg::t_cfg             cfg;
    qrd_pkg::t_div_cmd         div_cmd;
    qrd_pkg::t_div_sts         div_sts;
    logic [NW-1:0]             div_num;
    logic [NW-1:0]             div_quo;
    logic [qrd_pkg::REG_W-1:0] div_den;
    logic [qrd_pkg::REG_W-1:0] div_rem;

    qrd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    qrd_div #(.DEPTH_WIDTH(DEPTH_WIDTH)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (div_cmd),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_sts   (div_sts),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    qrd_ctrl #(.DEPTH_WIDTH(DEPTH_WIDTH)) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (cfg),
        .i_req_valid        (i_req.valid),
        .i_ic_depth         (i_req.ic_depth),
        .i_raid_depth       (i_req.raid_depth),
        .o_req_ready        (i_req.ready),
        .o_rsp_valid        (o_rsp.valid),
        .i_rsp_ready        (o_rsp.ready),
        .o_use_interconnect (o_rsp.use_interconnect),
        .o_hold_left        (o_rsp.hold_left),
        .o_div_cmd          (div_cmd),
        .o_div_num          (div_num),
        .o_div_den          (div_den),
        .i_div_sts          (div_sts),
        .i_div_quo          (div_quo),
        .i_div_rem          (div_rem)
    );

endmodule
